### design/lss_pkg.sv
// Shared types, codes and the exponential table builder for the stroke stabilizer.
`default_nettype none
package lss_pkg;

    localparam int unsigned EXP_DEPTH_DEFAULT = 256;
    localparam int unsigned CFG_DATA_W = 20;
    localparam int unsigned CFG_INDEX_W = 3;

    typedef enum logic [1:0] {
        OP_BEGIN  = 2'd0,
        OP_MOVE   = 2'd1,
        OP_TICK   = 2'd2,
        OP_FINISH = 2'd3
    } lss_op_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_RADIUS   = 3'd0,
        CFG_CATCH_EN = 3'd1,
        CFG_PULLED   = 3'd2,
        CFG_ON_END   = 3'd3,
        CFG_RATE     = 3'd4
    } lss_cfg_idx_t;

    typedef struct packed {
        logic [1:0]         op;
        logic signed [23:0] pos_x;
        logic signed [23:0] pos_y;
        logic [15:0]        dt;
    } lss_in_t;

    typedef struct packed {
        logic signed [23:0] out_x;
        logic signed [23:0] out_y;
    } lss_out_t;

    typedef enum logic [4:0] {
        DP_NONE,
        DP_LOAD,
        DP_BEGIN,
        DP_RAW,
        DP_PASS,
        DP_DIFF,
        DP_SQX,
        DP_SQY,
        DP_SQRT_INIT,
        DP_SQRT_STEP,
        DP_MOVE_MUL,
        DP_DIV_INIT,
        DP_DIV_STEP,
        DP_MOVE_UPD,
        DP_RATE,
        DP_INDEX,
        DP_EXP,
        DP_TICK_MUL,
        DP_TICK_RND,
        DP_TICK_UPD
    } lss_dp_op_t;

    typedef struct packed {
        lss_dp_op_t op;
        logic       axis;
        logic       out_load;
    } lss_cmd_t;

    typedef struct packed {
        lss_op_t op;
        logic    radius_zero;
        logic    on_end;
        logic    tick_ok;
        logic    sum_gt;
        logic    steps_zero;
    } lss_status_t;

    // Entry i of exp(-16*i/depth) in Q1.30; h is 16/depth in Q0.30.
    function automatic logic [30:0] lss_exp_entry(input int unsigned i, input logic [63:0] h);
        logic [63:0] term;
        logic signed [63:0] sum;
        logic [63:0] c;
        logic [63:0] e;
        term = 64'd1 << 30;
        sum = 64'sd1 <<< 30;
        for (int unsigned k = 1; k < 24; k++) begin
            if (term != 64'd0) begin
                term = ((term * h) >> 30) / 64'(k);
                if (k[0])
                    sum = sum - $signed(term);
                else
                    sum = sum + $signed(term);
            end
        end
        c = (sum < 0) ? 64'd0 : 64'(sum);
        e = 64'd1 << 30;
        for (int unsigned j = 1; j <= i; j++) begin
            e = (e * c + (64'd1 << 29)) >> 30;
        end
        return e[30:0];
    endfunction

endpackage
`default_nettype wire

### design/leash_stroke_stabilizer.sv
// Top level of the leash stroke stabilizer: controller and datapath.
// One request is worked at a time; the next is taken once the previous one has left the
// datapath, while its result may still wait in the output register. A move that pulls
// the leash runs the 32-step bit-serial square root and the two 25-step restoring
// divisions that share one divider; a tick runs a multiply, a table read and two
// rounding multiplies. The exponential table is built at elaboration, so no clearing
// pass follows reset.
`default_nettype none
module leash_stroke_stabilizer
    import lss_pkg::*;
#(
    parameter int unsigned EXP_TABLE_DEPTH = EXP_DEPTH_DEFAULT
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   evt_valid,
    output logic                        evt_stall,
    input  wire lss_in_t                evt,
    output logic                        res_valid,
    input  wire logic                   res_stall,
    output lss_out_t                    res,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    lss_cmd_t    cmd;
    lss_status_t status;

    lss_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .evt_valid (evt_valid),
        .evt_stall (evt_stall),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .status    (status),
        .cmd       (cmd)
    );

    lss_datapath #(
        .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .evt       (evt),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .res       (res)
    );

endmodule
`default_nettype wire

### design/lss_datapath.sv
// Datapath of the stroke stabilizer: state, configuration, square root, divider and table.
`default_nettype none
module lss_datapath
    import lss_pkg::*;
#(
    parameter int unsigned EXP_TABLE_DEPTH = EXP_DEPTH_DEFAULT
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire lss_in_t                evt,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    input  wire lss_cmd_t               cmd,
    output lss_status_t                 status,
    output lss_out_t                    res
);

    localparam int unsigned AW = $clog2(EXP_TABLE_DEPTH + 1);
    localparam logic [63:0] H = (64'd16 << 30) / EXP_TABLE_DEPTH;

    logic [19:0] radius_reg;
    logic        catch_en_reg;
    logic        pulled_reg;
    logic        on_end_reg;
    logic [15:0] rate_reg;

    lss_in_t            in_reg;
    logic signed [23:0] raw_x_reg, raw_y_reg, smooth_x_reg, smooth_y_reg;
    logic               begun_reg;
    logic signed [24:0] dx_reg, dy_reg;
    logic [48:0]        sqa_reg, sqb_reg;
    logic [39:0]        rsq_reg;
    logic [63:0]        sv_reg, sres_reg, sbit_reg;
    logic [56:0]        prod_reg;
    logic [31:0]        drem_reg;
    logic [24:0]        dlow_reg;
    logic [31:0]        x_reg;
    logic [AW-1:0]      addr_reg;
    logic               over_reg;
    logic [30:0]        e_reg;
    logic [24:0]        tstep_x_reg, tstep_y_reg;
    lss_out_t           res_reg;

    logic [30:0] exp_rom [EXP_TABLE_DEPTH+1];

    for (genvar g = 0; g <= EXP_TABLE_DEPTH; g++) begin : g_rom
        assign exp_rom[g] = lss_exp_entry(g, H);
    end

    logic [24:0] mag_x, mag_y, mag;
    logic        neg;
    logic [49:0] sum;
    logic [63:0] strial;
    logic [31:0] s_val, diff;
    logic [32:0] rem2;
    logic        ge;
    logic [47:0] xs;
    logic [19:0] idx;
    logic [30:0] f;
    logic [56:0] rnd;
    logic [23:0] upd_q, upd_x, upd_y;

    always_comb
    begin
        mag_x = dx_reg[24] ? 25'(-dx_reg) : 25'(dx_reg);
        mag_y = dy_reg[24] ? 25'(-dy_reg) : 25'(dy_reg);
        mag = cmd.axis ? mag_y : mag_x;
        neg = cmd.axis ? dy_reg[24] : dx_reg[24];
        sum = 50'(sqa_reg) + 50'(sqb_reg);
        strial = sres_reg + sbit_reg;
        s_val = sres_reg[31:0];
        diff = s_val - 32'({radius_reg, 7'd0});
        rem2 = {drem_reg, dlow_reg[24]};
        ge = rem2 >= {1'b0, s_val};
        xs = 48'(x_reg) * 48'(EXP_TABLE_DEPTH) + (48'd1 << 27);
        idx = xs[47:28];
        f = 31'(31'd1 << 30) - e_reg;
        rnd = prod_reg + (57'd1 << 29);
        upd_q = neg ? (24'd0 - dlow_reg[23:0]) : dlow_reg[23:0];
        upd_x = dx_reg[24] ? (24'd0 - tstep_x_reg[23:0]) : tstep_x_reg[23:0];
        upd_y = dy_reg[24] ? (24'd0 - tstep_y_reg[23:0]) : tstep_y_reg[23:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= '0;
            catch_en_reg <= 1'b0;
            pulled_reg <= 1'b0;
            on_end_reg <= 1'b0;
            rate_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (lss_cfg_idx_t'(cfg_index))
                CFG_RADIUS:   radius_reg <= cfg_data;
                CFG_CATCH_EN: catch_en_reg <= cfg_data[0];
                CFG_PULLED:   pulled_reg <= cfg_data[0];
                CFG_ON_END:   on_end_reg <= cfg_data[0];
                CFG_RATE:     rate_reg <= cfg_data[15:0];
                default:      ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            raw_x_reg <= '0;
            raw_y_reg <= '0;
            smooth_x_reg <= '0;
            smooth_y_reg <= '0;
            begun_reg <= 1'b0;
        end
        else
        begin
            unique case (cmd.op)
                DP_BEGIN:
                begin
                    raw_x_reg <= in_reg.pos_x;
                    raw_y_reg <= in_reg.pos_y;
                    smooth_x_reg <= in_reg.pos_x;
                    smooth_y_reg <= in_reg.pos_y;
                    begun_reg <= 1'b1;
                end
                DP_RAW:
                begin
                    raw_x_reg <= in_reg.pos_x;
                    raw_y_reg <= in_reg.pos_y;
                end
                DP_PASS:
                begin
                    smooth_x_reg <= raw_x_reg;
                    smooth_y_reg <= raw_y_reg;
                end
                DP_MOVE_UPD:
                begin
                    if (cmd.axis)
                        smooth_y_reg <= smooth_y_reg + $signed(upd_q);
                    else
                        smooth_x_reg <= smooth_x_reg + $signed(upd_q);
                end
                DP_TICK_UPD:
                begin
                    smooth_x_reg <= smooth_x_reg + $signed(upd_x);
                    smooth_y_reg <= smooth_y_reg + $signed(upd_y);
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            DP_LOAD: in_reg <= evt;
            DP_DIFF:
            begin
                dx_reg <= 25'(raw_x_reg) - 25'(smooth_x_reg);
                dy_reg <= 25'(raw_y_reg) - 25'(smooth_y_reg);
            end
            DP_SQX: sqa_reg <= 49'(mag_x) * 49'(mag_x);
            DP_SQY:
            begin
                sqb_reg <= 49'(mag_y) * 49'(mag_y);
                rsq_reg <= 40'(radius_reg) * 40'(radius_reg);
            end
            DP_SQRT_INIT:
            begin
                sv_reg <= {sum, 14'd0};
                sres_reg <= '0;
                sbit_reg <= 64'd1 << 62;
            end
            DP_SQRT_STEP:
            begin
                if (sv_reg >= strial)
                begin
                    sv_reg <= sv_reg - strial;
                    sres_reg <= (sres_reg >> 1) + sbit_reg;
                end
                else
                begin
                    sres_reg <= sres_reg >> 1;
                end
                sbit_reg <= sbit_reg >> 2;
            end
            DP_MOVE_MUL: prod_reg <= 57'(mag) * 57'(diff) + 57'(s_val >> 1);
            DP_DIV_INIT:
            begin
                drem_reg <= prod_reg[56:25];
                dlow_reg <= prod_reg[24:0];
            end
            DP_DIV_STEP:
            begin
                drem_reg <= ge ? 32'(rem2 - {1'b0, s_val}) : rem2[31:0];
                dlow_reg <= {dlow_reg[23:0], ge};
            end
            DP_RATE: x_reg <= 32'(rate_reg) * 32'(in_reg.dt);
            DP_INDEX:
            begin
                addr_reg <= idx[AW-1:0];
                over_reg <= idx > 20'(EXP_TABLE_DEPTH);
            end
            DP_EXP: e_reg <= over_reg ? 31'd0 : exp_rom[addr_reg];
            DP_TICK_MUL: prod_reg <= 57'(mag) * 57'(f);
            DP_TICK_RND:
            begin
                if (cmd.axis)
                    tstep_y_reg <= rnd[54:30];
                else
                    tstep_x_reg <= rnd[54:30];
            end
            default: ;
        endcase
        if (cmd.out_load)
        begin
            res_reg.out_x <= smooth_x_reg;
            res_reg.out_y <= smooth_y_reg;
        end
    end

    always_comb
    begin
        status.op = lss_op_t'(in_reg.op);
        status.radius_zero = radius_reg == 20'd0;
        status.on_end = on_end_reg;
        status.tick_ok = begun_reg && (radius_reg != 20'd0) && catch_en_reg && !pulled_reg;
        status.sum_gt = 50'(rsq_reg) < sum;
        status.steps_zero = (tstep_x_reg == 25'd0) && (tstep_y_reg == 25'd0);
    end

    assign res = res_reg;

endmodule
`default_nettype wire

### design/lss_controller.sv
// Controller of the stroke stabilizer: sequences each request through the datapath.
`default_nettype none
module lss_controller
    import lss_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        evt_valid,
    output logic             evt_stall,
    output logic             res_valid,
    input  wire logic        res_stall,
    input  wire lss_status_t status,
    output lss_cmd_t         cmd
);

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DEC,
        ST_MCHK,
        ST_FCHK,
        ST_SQX,
        ST_SQY,
        ST_CMP,
        ST_SQRT,
        ST_MMUL,
        ST_DINIT,
        ST_DIV,
        ST_MUPD,
        ST_TRATE,
        ST_TIDX,
        ST_TEXP,
        ST_TMUL,
        ST_TRND,
        ST_TZERO,
        ST_EMIT
    } state_t;

    state_t      state_reg, state_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        axis_reg, axis_next;
    logic        res_valid_reg, res_valid_next;

    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        axis_next = axis_reg;
        res_valid_next = res_valid_reg && res_stall;
        cmd.op = DP_NONE;
        cmd.axis = axis_reg;
        cmd.out_load = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (evt_valid)
                begin
                    cmd.op = DP_LOAD;
                    state_next = ST_DEC;
                end
            end
            ST_DEC:
            begin
                unique case (status.op)
                    OP_BEGIN:
                    begin
                        cmd.op = DP_BEGIN;
                        state_next = ST_IDLE;
                    end
                    OP_MOVE:
                    begin
                        cmd.op = DP_RAW;
                        state_next = ST_MCHK;
                    end
                    OP_TICK:
                    begin
                        if (status.tick_ok)
                        begin
                            cmd.op = DP_DIFF;
                            state_next = ST_TRATE;
                        end
                        else
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                    OP_FINISH:
                    begin
                        cmd.op = DP_RAW;
                        state_next = ST_FCHK;
                    end
                endcase
            end
            ST_MCHK:
            begin
                if (status.radius_zero)
                begin
                    cmd.op = DP_PASS;
                    state_next = ST_EMIT;
                end
                else
                begin
                    cmd.op = DP_DIFF;
                    state_next = ST_SQX;
                end
            end
            ST_FCHK:
            begin
                if (status.radius_zero || status.on_end)
                    cmd.op = DP_PASS;
                state_next = ST_EMIT;
            end
            ST_SQX:
            begin
                cmd.op = DP_SQX;
                state_next = ST_SQY;
            end
            ST_SQY:
            begin
                cmd.op = DP_SQY;
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                if (status.sum_gt)
                begin
                    cmd.op = DP_SQRT_INIT;
                    cnt_next = 5'd31;
                    state_next = ST_SQRT;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_SQRT:
            begin
                cmd.op = DP_SQRT_STEP;
                cnt_next = cnt_reg - 5'd1;
                if (cnt_reg == 5'd0)
                begin
                    axis_next = 1'b0;
                    state_next = ST_MMUL;
                end
            end
            ST_MMUL:
            begin
                cmd.op = DP_MOVE_MUL;
                state_next = ST_DINIT;
            end
            ST_DINIT:
            begin
                cmd.op = DP_DIV_INIT;
                cnt_next = 5'd24;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.op = DP_DIV_STEP;
                cnt_next = cnt_reg - 5'd1;
                if (cnt_reg == 5'd0)
                    state_next = ST_MUPD;
            end
            ST_MUPD:
            begin
                cmd.op = DP_MOVE_UPD;
                axis_next = 1'b1;
                state_next = axis_reg ? ST_EMIT : ST_MMUL;
            end
            ST_TRATE:
            begin
                cmd.op = DP_RATE;
                state_next = ST_TIDX;
            end
            ST_TIDX:
            begin
                cmd.op = DP_INDEX;
                state_next = ST_TEXP;
            end
            ST_TEXP:
            begin
                cmd.op = DP_EXP;
                axis_next = 1'b0;
                state_next = ST_TMUL;
            end
            ST_TMUL:
            begin
                cmd.op = DP_TICK_MUL;
                state_next = ST_TRND;
            end
            ST_TRND:
            begin
                cmd.op = DP_TICK_RND;
                axis_next = 1'b1;
                state_next = axis_reg ? ST_TZERO : ST_TMUL;
            end
            ST_TZERO:
            begin
                if (status.steps_zero)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.op = DP_TICK_UPD;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (!res_valid_reg || !res_stall)
                begin
                    cmd.out_load = 1'b1;
                    res_valid_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg <= '0;
            axis_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            axis_reg <= axis_next;
            res_valid_reg <= res_valid_next;
        end
    end

    assign evt_stall = state_reg != ST_IDLE;
    assign res_valid = res_valid_reg;

    a_result_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past(state_reg == ST_EMIT))
        else $error("result raised outside the emit step");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (evt_valid && !evt_stall) |=> (state_reg == ST_DEC))
        else $error("accepted request not decoded");

    a_sqrt_ends_in_mul: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SQRT && cnt_reg == 5'd0) |=> (state_reg == ST_MMUL && !axis_reg))
        else $error("square root did not hand over to the x axis");

    a_pending_held: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_stall) |=> res_valid_reg)
        else $error("stalled result dropped");

endmodule
`default_nettype wire

### dv/lss_checker.sv
// Request and result monitor with a reference predictor and in-order comparison for the stabilizer.
module lss_checker
    import lss_pkg::*;
#(
    parameter int unsigned DEPTH = EXP_DEPTH_DEFAULT
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   evt_valid,
    input  wire logic                   evt_stall,
    input  wire lss_in_t                evt,
    input  wire logic                   res_valid,
    input  wire logic                   res_stall,
    input  wire lss_out_t               res,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    output int                          errors,
    output int                          pending,
    output int                          results
);

    logic [19:0]        radius;
    logic               catch_en;
    logic               pulled;
    logic               on_end;
    logic [15:0]        rate;
    logic signed [23:0] raw_x;
    logic signed [23:0] raw_y;
    logic signed [23:0] smooth_x;
    logic signed [23:0] smooth_y;
    logic               begun;
    longint unsigned    decay_q30 [0:DEPTH];
    lss_out_t           expected_positions [$];

    initial
    begin
        longint unsigned h;
        longint unsigned term;
        longint          acc;
        longint unsigned c;
        errors = 0;
        results = 0;
        h = (64'd16 << 30) / DEPTH;
        term = 64'd1 << 30;
        acc = 64'sd1 << 30;
        for (int k = 1; k < 24; k++)
        begin
            if (term != 0)
            begin
                term = ((term * h) >> 30) / k;
                acc = (k % 2 == 1) ? acc - longint'(term) : acc + longint'(term);
            end
        end
        c = (acc < 0) ? 0 : longint'(acc);
        decay_q30[0] = 64'd1 << 30;
        for (int i = 1; i <= DEPTH; i++)
            decay_q30[i] = (decay_q30[i-1] * c + (64'd1 << 29)) >> 30;
    end

    assign pending = expected_positions.size();

    function automatic longint unsigned root_floor(input longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint scaled_step(input longint d, input longint unsigned num,
                                           input longint unsigned den);
        longint unsigned mag;
        longint unsigned q;
        mag = (d < 0) ? longint'(-d) : longint'(d);
        q = (mag * num + den / 2) / den;
        return (d < 0) ? -longint'(q) : longint'(q);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        longint          dx;
        longint          dy;
        longint unsigned sq;
        longint unsigned s;
        longint unsigned rr;
        longint unsigned idx;
        longint unsigned f;
        longint          sx;
        longint          sy;
        lss_out_t        got;
        lss_out_t        want;
        if (!rst_n)
        begin
            radius <= '0;
            catch_en <= 1'b0;
            pulled <= 1'b0;
            on_end <= 1'b0;
            rate <= '0;
            raw_x <= '0;
            raw_y <= '0;
            smooth_x <= '0;
            smooth_y <= '0;
            begun <= 1'b0;
            expected_positions.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_RADIUS:   radius <= cfg_data[19:0];
                    CFG_CATCH_EN: catch_en <= cfg_data[0];
                    CFG_PULLED:   pulled <= cfg_data[0];
                    CFG_ON_END:   on_end <= cfg_data[0];
                    CFG_RATE:     rate <= cfg_data[15:0];
                    default:      ;
                endcase
            end
            if (evt_valid && !evt_stall)
            begin
                case (evt.op)
                    OP_BEGIN:
                    begin
                        raw_x <= evt.pos_x;
                        raw_y <= evt.pos_y;
                        smooth_x <= evt.pos_x;
                        smooth_y <= evt.pos_y;
                        begun <= 1'b1;
                    end
                    OP_MOVE:
                    begin
                        raw_x <= evt.pos_x;
                        raw_y <= evt.pos_y;
                        want.out_x = smooth_x;
                        want.out_y = smooth_y;
                        if (radius == 0)
                        begin
                            want.out_x = evt.pos_x;
                            want.out_y = evt.pos_y;
                        end
                        else
                        begin
                            dx = longint'(evt.pos_x) - longint'(smooth_x);
                            dy = longint'(evt.pos_y) - longint'(smooth_y);
                            sq = dx * dx + dy * dy;
                            if (sq > longint'(radius) * longint'(radius))
                            begin
                                s = root_floor(sq << 14);
                                rr = longint'(radius) << 7;
                                want.out_x = smooth_x + 24'(scaled_step(dx, s - rr, s));
                                want.out_y = smooth_y + 24'(scaled_step(dy, s - rr, s));
                            end
                        end
                        smooth_x <= want.out_x;
                        smooth_y <= want.out_y;
                        expected_positions.push_back(want);
                    end
                    OP_TICK:
                    begin
                        if (begun && radius != 0 && catch_en && !pulled)
                        begin
                            idx = ((longint'(rate) * evt.dt) * DEPTH + (64'd1 << 27)) >> 28;
                            f = (64'd1 << 30) - ((idx <= DEPTH) ? decay_q30[idx] : 64'd0);
                            dx = longint'(raw_x) - longint'(smooth_x);
                            dy = longint'(raw_y) - longint'(smooth_y);
                            sx = scaled_step(dx, f, 64'd1 << 30);
                            sy = scaled_step(dy, f, 64'd1 << 30);
                            if (sx != 0 || sy != 0)
                            begin
                                want.out_x = smooth_x + 24'(sx);
                                want.out_y = smooth_y + 24'(sy);
                                smooth_x <= want.out_x;
                                smooth_y <= want.out_y;
                                expected_positions.push_back(want);
                            end
                        end
                    end
                    default:
                    begin
                        raw_x <= evt.pos_x;
                        raw_y <= evt.pos_y;
                        want.out_x = smooth_x;
                        want.out_y = smooth_y;
                        if (radius == 0 || on_end)
                        begin
                            want.out_x = evt.pos_x;
                            want.out_y = evt.pos_y;
                        end
                        smooth_x <= want.out_x;
                        smooth_y <= want.out_y;
                        expected_positions.push_back(want);
                    end
                endcase
            end
            if (res_valid && !res_stall)
            begin
                got = res;
                results <= results + 1;
                if (expected_positions.size() == 0)
                begin
                    $display("%0t: unexpected result x=%0d y=%0d", $realtime, got.out_x,
                             got.out_y);
                    errors <= errors + 1;
                end
                else
                begin
                    want = expected_positions.pop_front();
                    if (got.out_x !== want.out_x)
                    begin
                        $display("%0t: out_x expected %0d actual %0d", $realtime, want.out_x,
                                 got.out_x);
                        errors <= errors + 1;
                    end
                    else if (got.out_y !== want.out_y)
                    begin
                        $display("%0t: out_y expected %0d actual %0d", $realtime, want.out_y,
                                 got.out_y);
                        errors <= errors + 1;
                    end
                end
            end
        end
    end

endmodule

### dv/tb_leash_stroke_stabilizer.sv
// Testbench top for the stroke stabilizer: clock, reset, stimulus, idling and verdict.
module tb_leash_stroke_stabilizer;
    import lss_pkg::*;

    localparam int IDLE_LIMIT = 20000;

    logic                   clk;
    logic                   rst_n;
    logic                   evt_valid;
    logic                   evt_stall;
    lss_in_t                evt;
    logic                   res_valid;
    logic                   res_stall;
    lss_out_t               res;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    int                     errors;
    int                     pending;
    int                     results;
    int                     requests_sent;
    int                     burst_left;
    int                     idle_cycles;
    int                     stall_mode;
    int                     mode_left;
    logic signed [23:0]     pen_x;
    logic signed [23:0]     pen_y;

    leash_stroke_stabilizer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .evt_valid (evt_valid),
        .evt_stall (evt_stall),
        .evt       (evt),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    lss_checker checker_i (
        .clk       (clk),
        .rst_n     (rst_n),
        .evt_valid (evt_valid),
        .evt_stall (evt_stall),
        .evt       (evt),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .errors    (errors),
        .pending   (pending),
        .results   (results)
    );

    initial
    begin
        clk = 1'b0;
        forever
            #4 clk = ~clk;
    end

    initial
    begin
        stall_mode = 0;
        mode_left = 0;
        res_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (mode_left == 0)
            begin
                stall_mode <= $urandom_range(0, 3);
                mode_left <= $urandom_range(20, 300);
            end
            else
                mode_left <= mode_left - 1;
            case (stall_mode)
                0:       res_stall <= 1'b0;
                1:       res_stall <= ($urandom_range(0, 1) == 1);
                2:       res_stall <= ($urandom_range(0, 9) != 0);
                default: res_stall <= ($urandom_range(0, 31) < 3);
            endcase
        end
    end

    always @(posedge clk)
    begin
        if ((evt_valid && !evt_stall) || (res_valid && !res_stall) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic send(input lss_op_t op, input logic signed [23:0] x,
                        input logic signed [23:0] y, input logic [15:0] dt);
        lss_in_t item;
        item.op = op;
        item.pos_x = x;
        item.pos_y = y;
        item.dt = dt;
        evt <= item;
        evt_valid <= 1'b1;
        do
            @(posedge clk);
        while (evt_stall);
        requests_sent++;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            evt_valid <= 1'b0;
            repeat ($urandom_range(1, 40))
                @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
        end
    endtask

    task automatic drain();
        evt_valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (150)
            @(posedge clk);
    endtask

    task automatic configure(input logic [19:0] radius, input logic en, input logic pulled,
                             input logic on_end, input logic [15:0] rate);
        drain();
        cfg_we <= 1'b1;
        cfg_index <= CFG_RADIUS;
        cfg_data <= radius;
        @(posedge clk);
        cfg_index <= CFG_CATCH_EN;
        cfg_data <= 20'(en);
        @(posedge clk);
        cfg_index <= CFG_PULLED;
        cfg_data <= 20'(pulled);
        @(posedge clk);
        cfg_index <= CFG_ON_END;
        cfg_data <= 20'(on_end);
        @(posedge clk);
        cfg_index <= CFG_RATE;
        cfg_data <= 20'(rate);
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic signed [23:0] offset(input logic signed [23:0] base);
        int k;
        int mag;
        k = $urandom_range(0, 3);
        case (k)
            0:       return 24'($urandom);
            1:       mag = $urandom_range(0, 255);
            2:       mag = $urandom_range(0, 1 << 14);
            default: mag = $urandom_range(0, 1 << $urandom_range(0, 22));
        endcase
        return ($urandom_range(0, 1) == 1) ? base + 24'(mag) : base - 24'(mag);
    endfunction

    task automatic random_stroke();
        int n;
        pen_x = offset(pen_x);
        pen_y = offset(pen_y);
        send(OP_BEGIN, pen_x, pen_y, 16'($urandom));
        n = $urandom_range(1, 12);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 2) == 0)
                send(OP_TICK, 24'($urandom), 24'($urandom), 16'($urandom));
            else
            begin
                pen_x = offset(pen_x);
                pen_y = offset(pen_y);
                send(OP_MOVE, pen_x, pen_y, 16'($urandom));
            end
        end
        if ($urandom_range(0, 1) == 0)
            send(OP_TICK, 24'($urandom), 24'($urandom), 16'($urandom_range(0, 255)));
        pen_x = offset(pen_x);
        pen_y = offset(pen_y);
        send(OP_FINISH, pen_x, pen_y, 16'($urandom));
    endtask

    initial
    begin
        logic [19:0] radius;
        rst_n = 1'b0;
        evt_valid = 1'b0;
        evt = '0;
        cfg_we = 1'b0;
        cfg_index = CFG_RADIUS;
        cfg_data = '0;
        requests_sent = 0;
        burst_left = 0;
        idle_cycles = 0;
        pen_x = '0;
        pen_y = '0;
        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Events before any begin, then pass-through with zero radius.
        send(OP_MOVE, 24'sh7FFFFF, 24'sh800000, 16'hFFFF);
        send(OP_TICK, 24'sd0, 24'sd0, 16'hFFFF);
        send(OP_FINISH, 24'sh800000, 24'sh7FFFFF, 16'h0000);
        send(OP_BEGIN, 24'sh800000, 24'sh800000, 16'h0000);
        send(OP_MOVE, 24'sh7FFFFF, 24'sh7FFFFF, 16'h0000);
        send(OP_TICK, 24'sd0, 24'sd0, 16'h8000);
        send(OP_FINISH, 24'sd5, -24'sd5, 16'h0000);

        configure(20'hFFFFF, 1'b1, 1'b0, 1'b0, 16'hFFFF);
        send(OP_BEGIN, 24'sh800000, 24'sh800000, 16'h0000);
        send(OP_MOVE, 24'sh7FFFFF, 24'sh7FFFFF, 16'h0000);
        send(OP_MOVE, 24'sh800000, 24'sh800010, 16'h0000);
        send(OP_MOVE, 24'sh800001, 24'sh800000, 16'h0000);
        send(OP_TICK, 24'sd0, 24'sd0, 16'h0000);
        send(OP_TICK, 24'sd0, 24'sd0, 16'hFFFF);
        send(OP_FINISH, 24'sd0, 24'sd0, 16'h0000);

        configure(20'd1, 1'b1, 1'b0, 1'b1, 16'd256);
        send(OP_BEGIN, 24'sd0, 24'sd0, 16'h0000);
        send(OP_MOVE, 24'sd3, -24'sd4, 16'h0000);
        send(OP_TICK, 24'sd0, 24'sd0, 16'd1);
        send(OP_TICK, 24'sd0, 24'sd0, 16'h4000);
        send(OP_FINISH, 24'sd100, 24'sd100, 16'h0000);

        configure(20'd512, 1'b1, 1'b1, 1'b0, 16'd1000);
        send(OP_BEGIN, 24'sd0, 24'sd0, 16'h0000);
        send(OP_MOVE, 24'sd4000, 24'sd0, 16'h0000);
        send(OP_TICK, 24'sd0, 24'sd0, 16'hFFFF);
        send(OP_FINISH, 24'sd4000, 24'sd0, 16'h0000);

        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase % 4)
                0:       radius = 20'($urandom_range(1, 4096));
                1:       radius = 20'($urandom);
                2:       radius = 20'd0;
                default: radius = 20'($urandom_range(1, 64));
            endcase
            configure(radius, ($urandom_range(0, 3) != 0), ($urandom_range(0, 3) == 0),
                      1'($urandom_range(0, 1)), (phase == 5) ? 16'hFFFF : 16'($urandom));
            while (requests_sent < 210 * (phase + 1))
            begin
                if ($urandom_range(0, 9) == 0)
                    send(lss_op_t'($urandom_range(0, 3)), 24'($urandom), 24'($urandom),
                         16'($urandom));
                else
                    random_stroke();
            end
        end

        drain();
        $display("Sent %0d requests over twelve register settings and checked %0d results.",
                 requests_sent, results);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
